### src/dvrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dvrt_pkg;

	localparam int unsigned MAX_RESULTS = 64;
	localparam int unsigned EMIT_W = 7;

	localparam logic [4:0] INF_METRIC = 5'd16;

	localparam logic [1:0] OP_RECV    = 2'd0;
	localparam logic [1:0] OP_PERIOD  = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;

	localparam logic [7:0] RIP_VER     = 8'd2;
	localparam logic [7:0] CMD_REQUEST = 8'd1;
	localparam logic [7:0] CMD_RESPONSE = 8'd2;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_ADV    = 2'd1;
	localparam logic [1:0] KIND_EMPTY  = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_VERSION   = 3'd1;
	localparam logic [2:0] ST_COMMAND   = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	typedef struct packed {
		logic [31:0] dest;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [4:0]  metric;
		logic [7:0]  iface;
	} entry_t;

	typedef struct packed {
		logic match;
		logic elig;
		logic nh_eq;
		logic met_lt;
	} cmp_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  status;
		logic [7:0]  iface;
		logic [31:0] dest;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [4:0]  metric;
		logic        packet_end;
		logic        last;
	} result_t;

endpackage
`default_nettype wire

### src/dvrt_table.sv
`timescale 1ns / 1ps
`default_nettype none
module dvrt_table #(
	parameter int DEPTH = 32,
	parameter int AW = 5
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire dvrt_pkg::entry_t wdata,
	input  wire logic [AW-1:0]    raddr,
	output dvrt_pkg::entry_t      rdata
);

	dvrt_pkg::entry_t mem [DEPTH];
	dvrt_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### src/dvrt_cmp.sv
`timescale 1ns / 1ps
`default_nettype none
module dvrt_cmp (
	input  wire dvrt_pkg::entry_t ent,
	input  wire logic [31:0]      dest,
	input  wire logic [31:0]      mask,
	input  wire logic [31:0]      src,
	input  wire logic [31:0]      metric,
	input  wire logic [7:0]       adv_iface,
	output dvrt_pkg::cmp_t        res
);

	always_comb begin
		res.match  = (ent.dest == dest) && (ent.mask == mask);
		res.elig   = (ent.iface != adv_iface) && (ent.metric < dvrt_pkg::INF_METRIC);
		res.nh_eq  = (ent.gateway == src);
		res.met_lt = (metric < {27'd0, ent.metric});
	end

endmodule
`default_nettype wire

### src/distance_vector_route_table.sv
`timescale 1ns / 1ps
`default_nettype none
// RIPv2 route table engine. Each input transfer is a received packet entry, a periodic
// advertisement or a route timeout. One item is taken at a time: updates and timeouts walk
// the table one entry per cycle through a single read port and a shared compare unit, and
// the walk stops early on the first match. A request advertisement walks the table once;
// a periodic advertisement walks it once per interface. Errors and non-final requests do
// not walk the table. Every item is held up for as long as the output side stalls.
module distance_vector_route_table #(
	parameter int TABLE_DEPTH = 32,
	parameter int ENTRIES_PER_PACKET = 25
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// rip_version, rip_command, iface, source_addr, route_dest, route_mask, route_metric
	input  wire logic [151:0] s_tdata,
	input  wire logic         s_tlast,
	// opcode
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// status, out_iface, adv_dest, adv_mask, adv_gateway, adv_metric
	output logic [111:0]      m_tdata,
	output logic              m_tlast,
	// kind, packet_end
	output logic [2:0]        m_tuser
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int PW = $clog2(ENTRIES_PER_PACKET + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD  = 3'd1;
	localparam logic [2:0] S_WALK  = 3'd2;
	localparam logic [2:0] S_ADVE  = 3'd3;
	localparam logic [2:0] S_UPD   = 3'd4;
	localparam logic [2:0] S_STAT  = 3'd5;
	localparam logic [2:0] S_FLUSH = 3'd6;

	logic [2:0] state_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic [PW-1:0] place_q;
	logic [dvrt_pkg::EMIT_W-1:0] emitted_q;
	logic adv_q, fwd_q, two_q, found_q;
	logic [1:0] op_q;
	logic [7:0] ifc_q, adv_if_q;
	logic [31:0] src_q, dst_q, msk_q, met_q;
	logic [2:0] status_q;
	logic pend_v_q;
	dvrt_pkg::result_t pend_q, out_q, pend_fin;
	logic out_v_q;

	logic [AW-1:0] raddr, last_idx;
	logic we;
	logic [AW-1:0] waddr;
	dvrt_pkg::entry_t wdata, rd;
	dvrt_pkg::cmp_t cmp;

	logic out_free, at_end, can_put;
	logic [AW-1:0] next_idx;

	dvrt_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd)
	);

	dvrt_cmp u_cmp (
		.ent      (rd),
		.dest     (dst_q),
		.mask     (msk_q),
		.src      (src_q),
		.metric   (met_q),
		.adv_iface(adv_if_q),
		.res      (cmp)
	);

	assign out_free = !out_v_q || m_tready;
	assign last_idx = AW'(count_q - CW'(1));
	assign at_end = fwd_q ? (idx_q == last_idx) : (idx_q == '0);
	assign next_idx = fwd_q ? AW'(idx_q + AW'(1)) : AW'(idx_q - AW'(1));
	assign can_put = emitted_q < dvrt_pkg::EMIT_W'(dvrt_pkg::MAX_RESULTS);
	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		pend_fin = pend_q;
		pend_fin.last = 1'b1;
	end

	always_comb begin
		raddr = idx_q;
		if (state_q == S_LOAD) begin
			raddr = fwd_q ? '0 : last_idx;
		end else if (state_q == S_WALK && !at_end) begin
			if (adv_q) begin
				if (!(cmp.elig && can_put && pend_v_q && !out_free)) begin
					raddr = next_idx;
				end
			end else if (!cmp.match) begin
				raddr = next_idx;
			end
		end
	end

	always_comb begin
		we = 1'b0;
		waddr = idx_q;
		wdata = rd;
		if (state_q == S_UPD) begin
			if (op_q == dvrt_pkg::OP_TIMEOUT) begin
				we = found_q;
				wdata.metric = dvrt_pkg::INF_METRIC;
			end else if (found_q) begin
				we = cmp.nh_eq || cmp.met_lt;
				wdata.metric = (met_q >= 32'd15) ? dvrt_pkg::INF_METRIC : 5'(met_q + 32'd1);
				wdata.iface = ifc_q;
				if (!cmp.nh_eq) begin
					wdata.gateway = src_q;
				end
			end else begin
				we = (met_q < 32'd15) && (count_q < CW'(TABLE_DEPTH));
				waddr = AW'(count_q);
				wdata.dest = dst_q;
				wdata.mask = msk_q;
				wdata.gateway = src_q;
				wdata.metric = 5'(met_q + 32'd1);
				wdata.iface = ifc_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			pend_v_q <= 1'b0;
			pend_q <= '0;
			out_v_q <= 1'b0;
			out_q <= '0;
			emitted_q <= '0;
			place_q <= '0;
			found_q <= 1'b0;
			adv_q <= 1'b0;
			fwd_q <= 1'b0;
			two_q <= 1'b0;
			op_q <= dvrt_pkg::OP_RECV;
			ifc_q <= '0;
			adv_if_q <= '0;
			src_q <= '0;
			dst_q <= '0;
			msk_q <= '0;
			met_q <= '0;
			status_q <= dvrt_pkg::ST_OK;
		end else begin
			logic out_v_nxt;
			out_v_nxt = out_v_q && !m_tready;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q <= s_tuser;
						ifc_q <= s_tdata[23:16];
						src_q <= s_tdata[55:24];
						dst_q <= s_tdata[87:56];
						msk_q <= s_tdata[119:88];
						met_q <= s_tdata[151:120];
						emitted_q <= '0;
						place_q <= '0;
						found_q <= 1'b0;
						two_q <= (s_tuser == dvrt_pkg::OP_PERIOD);
						adv_q <= (s_tuser == dvrt_pkg::OP_PERIOD) ||
							(s_tuser == dvrt_pkg::OP_RECV &&
							s_tdata[15:8] == dvrt_pkg::CMD_REQUEST);
						fwd_q <= (s_tuser == dvrt_pkg::OP_RECV &&
							s_tdata[15:8] == dvrt_pkg::CMD_RESPONSE);
						adv_if_q <= (s_tuser == dvrt_pkg::OP_PERIOD) ? 8'd1 : s_tdata[23:16];
						unique case (s_tuser)
							dvrt_pkg::OP_RECV: begin
								if (s_tdata[7:0] != dvrt_pkg::RIP_VER) begin
									status_q <= dvrt_pkg::ST_VERSION;
									state_q <= S_STAT;
								end else if (s_tdata[15:8] == dvrt_pkg::CMD_REQUEST) begin
									status_q <= dvrt_pkg::ST_OK;
									if (s_tlast) begin
										state_q <= S_LOAD;
									end else begin
										state_q <= S_STAT;
									end
								end else if (s_tdata[15:8] == dvrt_pkg::CMD_RESPONSE) begin
									state_q <= S_LOAD;
								end else begin
									status_q <= dvrt_pkg::ST_COMMAND;
									state_q <= S_STAT;
								end
							end
							dvrt_pkg::OP_PERIOD: begin
								state_q <= S_LOAD;
							end
							dvrt_pkg::OP_TIMEOUT: begin
								state_q <= S_LOAD;
							end
							default: begin
								status_q <= dvrt_pkg::ST_COMMAND;
								state_q <= S_STAT;
							end
						endcase
					end
				end
				S_LOAD: begin
					idx_q <= raddr;
					if (count_q == '0) begin
						state_q <= adv_q ? S_ADVE : S_UPD;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (adv_q) begin
						if (!(cmp.elig && can_put && pend_v_q && !out_free)) begin
							if (cmp.elig) begin
								if (place_q == PW'(ENTRIES_PER_PACKET - 1)) begin
									place_q <= '0;
								end else begin
									place_q <= PW'(place_q + PW'(1));
								end
								if (can_put) begin
									if (pend_v_q) begin
										out_q <= pend_q;
										out_v_nxt = 1'b1;
									end
									pend_v_q <= 1'b1;
									pend_q <= '{kind: dvrt_pkg::KIND_ADV, status: dvrt_pkg::ST_OK,
										iface: adv_if_q, dest: rd.dest, mask: rd.mask,
										gateway: rd.gateway, metric: rd.metric,
										packet_end: (place_q == PW'(ENTRIES_PER_PACKET - 1)),
										last: 1'b0};
									emitted_q <= dvrt_pkg::EMIT_W'(emitted_q + 1'b1);
								end
							end
							idx_q <= raddr;
							if (at_end) begin
								state_q <= S_ADVE;
							end
						end
					end else if (cmp.match) begin
						found_q <= 1'b1;
						state_q <= S_UPD;
					end else begin
						idx_q <= raddr;
						if (at_end) begin
							state_q <= S_UPD;
						end
					end
				end
				S_ADVE: begin
					if (!(place_q == '0 && can_put && pend_v_q && !out_free)) begin
						if (place_q == '0) begin
							if (can_put) begin
								if (pend_v_q) begin
									out_q <= pend_q;
									out_v_nxt = 1'b1;
								end
								pend_v_q <= 1'b1;
								pend_q <= '{kind: dvrt_pkg::KIND_EMPTY, status: dvrt_pkg::ST_OK,
									iface: adv_if_q, dest: '0, mask: '0, gateway: '0,
									metric: '0, packet_end: 1'b1, last: 1'b0};
								emitted_q <= dvrt_pkg::EMIT_W'(emitted_q + 1'b1);
							end
						end else begin
							pend_q.packet_end <= 1'b1;
						end
						place_q <= '0;
						if (two_q) begin
							two_q <= 1'b0;
							adv_if_q <= 8'd2;
							state_q <= S_LOAD;
						end else begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_UPD: begin
					if (op_q == dvrt_pkg::OP_TIMEOUT) begin
						status_q <= found_q ? dvrt_pkg::ST_OK : dvrt_pkg::ST_NOT_FOUND;
					end else if (!found_q && met_q < 32'd15) begin
						if (count_q < CW'(TABLE_DEPTH)) begin
							count_q <= CW'(count_q + CW'(1));
							status_q <= dvrt_pkg::ST_OK;
						end else begin
							status_q <= dvrt_pkg::ST_FULL;
						end
					end else begin
						status_q <= dvrt_pkg::ST_OK;
					end
					state_q <= S_STAT;
				end
				S_STAT: begin
					if (out_free) begin
						out_q <= '{kind: dvrt_pkg::KIND_STATUS, status: status_q, iface: '0,
							dest: '0, mask: '0, gateway: '0, metric: '0,
							packet_end: 1'b0, last: 1'b1};
						out_v_nxt = 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_q <= pend_fin;
						out_v_nxt = 1'b1;
						pend_v_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			out_v_q <= out_v_nxt;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {out_q.metric, out_q.gateway, out_q.mask, out_q.dest, out_q.iface,
		out_q.status};
	assign m_tlast = out_q.last;
	assign m_tuser = {out_q.packet_end, out_q.kind};

`ifndef SYNTHESIS
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !pend_v_q)
		else $error("pending result left while idle");
	a_adv_metric: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1:0] == dvrt_pkg::KIND_ADV) |-> (m_tdata[111:107] < 5'd16))
		else $error("advertised metric not below infinity");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("route count beyond table depth");
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		emitted_q <= dvrt_pkg::EMIT_W'(dvrt_pkg::MAX_RESULTS))
		else $error("result count beyond limit");
`endif

endmodule
`default_nettype wire

### sim/tb_distance_vector_route_table.sv
`timescale 1ns / 1ps
module tb_distance_vector_route_table;

	localparam int DEPTH = 32;
	localparam int PER_PACKET = 25;

	class route_scoreboard;
		dvrt_pkg::result_t expq[$];
		int unsigned n_routes;
		logic [31:0] t_dest[DEPTH];
		logic [31:0] t_mask[DEPTH];
		logic [31:0] t_nh[DEPTH];
		logic [4:0]  t_metric[DEPTH];
		logic [7:0]  t_iface[DEPTH];
		dvrt_pkg::result_t item_q[$];
		int errors;
		int results_seen;
		int adv_seen;
		int full_seen;

		function void add(logic [1:0] kind, logic [2:0] st, logic [7:0] ifc, logic [31:0] d,
				logic [31:0] m, logic [31:0] nh, logic [4:0] met, logic pend);
			dvrt_pkg::result_t r;
			if (item_q.size() >= dvrt_pkg::MAX_RESULTS)
				return;
			r = '{kind, st, ifc, d, m, nh, met, pend, 1'b0};
			item_q.push_back(r);
		endfunction

		function void advertise(logic [7:0] ifc);
			int place;
			place = 0;
			for (int i = int'(n_routes) - 1; i >= 0; i--) begin
				if (t_iface[i] != ifc && t_metric[i] < dvrt_pkg::INF_METRIC) begin
					place++;
					add(dvrt_pkg::KIND_ADV, dvrt_pkg::ST_OK, ifc, t_dest[i], t_mask[i], t_nh[i],
						t_metric[i], place == PER_PACKET);
					if (place == PER_PACKET)
						place = 0;
				end
			end
			if (place == 0)
				add(dvrt_pkg::KIND_EMPTY, dvrt_pkg::ST_OK, ifc, '0, '0, '0, '0, 1'b1);
			else if (item_q.size() > 0)
				item_q[item_q.size() - 1].packet_end = 1'b1;
		endfunction

		function logic [2:0] update(logic [7:0] ifc, logic [31:0] src, logic [31:0] dst,
				logic [31:0] msk, logic [31:0] met);
			logic [32:0] newm;
			newm = {1'b0, met} + 33'd1;
			if (newm > 33'd16)
				newm = 33'd16;
			for (int i = 0; i < int'(n_routes); i++) begin
				if (t_dest[i] == dst && t_mask[i] == msk) begin
					if (src == t_nh[i]) begin
						t_metric[i] = newm[4:0];
						t_iface[i] = ifc;
					end else if (met < {27'd0, t_metric[i]}) begin
						t_metric[i] = newm[4:0];
						t_iface[i] = ifc;
						t_nh[i] = src;
					end
					return dvrt_pkg::ST_OK;
				end
			end
			if ({1'b0, met} + 33'd1 < 33'd16) begin
				if (n_routes >= DEPTH)
					return dvrt_pkg::ST_FULL;
				t_dest[n_routes] = dst;
				t_mask[n_routes] = msk;
				t_nh[n_routes] = src;
				t_metric[n_routes] = newm[4:0];
				t_iface[n_routes] = ifc;
				n_routes++;
			end
			return dvrt_pkg::ST_OK;
		endfunction

		function void note(logic [1:0] op, logic [7:0] ver, logic [7:0] cmd, logic [7:0] ifc,
				logic [31:0] src, logic [31:0] dst, logic [31:0] msk, logic [31:0] met,
				logic fin);
			logic [2:0] st;
			bit has_status;
			item_q.delete();
			has_status = 1;
			st = dvrt_pkg::ST_OK;
			if (op == dvrt_pkg::OP_RECV) begin
				if (ver != dvrt_pkg::RIP_VER)
					st = dvrt_pkg::ST_VERSION;
				else if (cmd != dvrt_pkg::CMD_REQUEST && cmd != dvrt_pkg::CMD_RESPONSE)
					st = dvrt_pkg::ST_COMMAND;
				else if (cmd == dvrt_pkg::CMD_REQUEST) begin
					if (fin) begin
						advertise(ifc);
						has_status = 0;
					end
				end else
					st = update(ifc, src, dst, msk, met);
			end else if (op == dvrt_pkg::OP_PERIOD) begin
				advertise(8'd1);
				advertise(8'd2);
				has_status = 0;
			end else if (op == dvrt_pkg::OP_TIMEOUT) begin
				st = dvrt_pkg::ST_NOT_FOUND;
				for (int i = int'(n_routes) - 1; i >= 0; i--) begin
					if (t_dest[i] == dst && t_mask[i] == msk) begin
						t_metric[i] = dvrt_pkg::INF_METRIC;
						st = dvrt_pkg::ST_OK;
						break;
					end
				end
			end else
				st = dvrt_pkg::ST_COMMAND;
			if (has_status)
				add(dvrt_pkg::KIND_STATUS, st, '0, '0, '0, '0, '0, 1'b0);
			if (st == dvrt_pkg::ST_FULL)
				full_seen++;
			if (item_q.size() > 0)
				item_q[item_q.size() - 1].last = 1'b1;
			foreach (item_q[k])
				expq.push_back(item_q[k]);
		endfunction

		function void check(dvrt_pkg::result_t act);
			dvrt_pkg::result_t e;
			results_seen++;
			if (act.kind == dvrt_pkg::KIND_ADV)
				adv_seen++;
			if (expq.size() == 0) begin
				$display("%0t: unexpected result %h", $time, act);
				errors++;
				return;
			end
			e = expq.pop_front();
			if (e.kind != act.kind || e.status != act.status || e.iface != act.iface
					|| e.dest != act.dest || e.mask != act.mask
					|| e.gateway != act.gateway || e.metric != act.metric
					|| e.packet_end != act.packet_end || e.last != act.last) begin
				$display("%0t: mismatch expected k%0d s%0d if%0d %h/%h nh %h m%0d pe%0d l%0d",
					$time, e.kind, e.status, e.iface, e.dest, e.mask, e.gateway, e.metric,
					e.packet_end, e.last);
				$display("%0t:            actual k%0d s%0d if%0d %h/%h nh %h m%0d pe%0d l%0d",
					$time, act.kind, act.status, act.iface, act.dest, act.mask, act.gateway,
					act.metric, act.packet_end, act.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [151:0] s_tdata;
	logic s_tlast;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [111:0] m_tdata;
	logic m_tlast;
	logic [2:0] m_tuser;

	distance_vector_route_table dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	route_scoreboard sb = new();
	logic [31:0] dest_pool[48];
	logic [31:0] mask_pool[3];
	logic [31:0] src_pool[4];
	int burst_left;
	int items_sent;
	int stall_mode;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("timeout, %0d results still pending", sb.expq.size());
		$display("** distance_vector_route_table: FAILED **");
		$finish;
	end

	always @(posedge clk) begin
		if ($urandom_range(0, 299) == 0)
			stall_mode <= int'($urandom_range(0, 2));
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 9) < 7);
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(negedge clk) begin
		dvrt_pkg::result_t r;
		if (arst_n && m_tvalid && m_tready) begin
			r.kind = m_tuser[1:0];
			r.packet_end = m_tuser[2];
			r.status = m_tdata[2:0];
			r.iface = m_tdata[10:3];
			r.dest = m_tdata[42:11];
			r.mask = m_tdata[74:43];
			r.gateway = m_tdata[106:75];
			r.metric = m_tdata[111:107];
			r.last = m_tlast;
			sb.check(r);
		end
	end

	task automatic send(logic [1:0] op, logic [7:0] ver, logic [7:0] cmd, logic [7:0] ifc,
			logic [31:0] src, logic [31:0] dst, logic [31:0] msk, logic [31:0] met,
			logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 40));
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = int'($urandom_range(1, 12));
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tlast <= fin;
		s_tdata <= {met, msk, dst, src, ifc, cmd, ver};
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		sb.note(op, ver, cmd, ifc, src, dst, msk, met, fin);
		items_sent++;
		@(posedge clk);
	endtask

	task automatic response(int d, int m, int s, logic [31:0] met, logic [7:0] ifc);
		send(dvrt_pkg::OP_RECV, dvrt_pkg::RIP_VER, dvrt_pkg::CMD_RESPONSE, ifc, src_pool[s],
			dest_pool[d], mask_pool[m], met, 1'($urandom_range(0, 1)));
	endtask

	task automatic random_item();
		int sel;
		logic [31:0] met;
		sel = int'($urandom_range(0, 99));
		met = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 16);
		if (sel < 58)
			response(int'($urandom_range(0, 47)), int'($urandom_range(0, 2)),
				int'($urandom_range(0, 3)), met, 8'($urandom_range(0, 3)));
		else if (sel < 66)
			send(dvrt_pkg::OP_RECV, dvrt_pkg::RIP_VER, dvrt_pkg::CMD_REQUEST,
				8'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(), $urandom(),
				1'($urandom_range(0, 1)));
		else if (sel < 76)
			send(dvrt_pkg::OP_PERIOD, 8'($urandom()), 8'($urandom()), 8'($urandom()),
				$urandom(), $urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)));
		else if (sel < 86)
			send(dvrt_pkg::OP_TIMEOUT, 8'($urandom()), 8'($urandom()), 8'($urandom()),
				$urandom(), dest_pool[$urandom_range(0, 47)], mask_pool[$urandom_range(0, 2)],
				$urandom(), 1'($urandom_range(0, 1)));
		else
			send(2'($urandom_range(0, 3)),
				(($urandom_range(0, 1) != 0) ? dvrt_pkg::RIP_VER : 8'($urandom())),
				(($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom())),
				8'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
				1'($urandom_range(0, 1)));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expq.size() != 0)
			@(posedge clk);
		repeat (DEPTH * 2 + 20) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		s_tuser = dvrt_pkg::OP_RECV;
		m_tready = 1'b0;
		stall_mode = 0;
		burst_left = 0;
		items_sent = 0;
		foreach (dest_pool[i])
			dest_pool[i] = $urandom();
		dest_pool[0] = '0;
		dest_pool[1] = '1;
		mask_pool[0] = 32'hFFFFFF00;
		mask_pool[1] = '1;
		mask_pool[2] = '0;
		src_pool[0] = 32'h0A000001;
		src_pool[1] = '1;
		src_pool[2] = '0;
		src_pool[3] = $urandom();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send(dvrt_pkg::OP_PERIOD, 8'd0, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
		send(dvrt_pkg::OP_TIMEOUT, 8'd0, 8'd0, 8'd0, 32'd0, dest_pool[0], mask_pool[0], 32'd0,
			1'b0);
		send(dvrt_pkg::OP_RECV, 8'd1, dvrt_pkg::CMD_RESPONSE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0,
			1'b1);
		send(dvrt_pkg::OP_RECV, 8'hFF, dvrt_pkg::CMD_RESPONSE, 8'd0, 32'd0, 32'd0, 32'd0,
			32'd0, 1'b1);
		send(dvrt_pkg::OP_RECV, dvrt_pkg::RIP_VER, 8'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0,
			1'b1);
		send(dvrt_pkg::OP_RECV, dvrt_pkg::RIP_VER, 8'd3, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0,
			1'b1);
		send(dvrt_pkg::OP_RECV, dvrt_pkg::RIP_VER, 8'hFF, 8'hFF, '1, '1, '1, '1, 1'b1);
		send(2'd3, '1, '1, '1, '1, '1, '1, '1, 1'b1);
		response(0, 0, 0, 32'd0, 8'd1);
		response(1, 1, 1, 32'd14, 8'd2);
		response(2, 2, 2, 32'd15, 8'd255);
		response(3, 0, 3, 32'hFFFFFFFF, 8'd0);
		response(4, 1, 0, 32'd3, 8'd3);
		response(0, 0, 0, 32'd5, 8'd2);
		response(0, 0, 1, 32'd1, 8'd1);
		response(4, 1, 2, 32'd9, 8'd1);
		send(dvrt_pkg::OP_RECV, dvrt_pkg::RIP_VER, dvrt_pkg::CMD_REQUEST, 8'd1, 32'd0, 32'd0,
			32'd0, 32'd0, 1'b0);
		send(dvrt_pkg::OP_RECV, dvrt_pkg::RIP_VER, dvrt_pkg::CMD_REQUEST, 8'd1, 32'd0, 32'd0,
			32'd0, 32'd0, 1'b1);
		send(dvrt_pkg::OP_RECV, dvrt_pkg::RIP_VER, dvrt_pkg::CMD_REQUEST, 8'd255, '1, '1, '1,
			'1, 1'b1);
		send(dvrt_pkg::OP_TIMEOUT, 8'd0, 8'd0, 8'd0, 32'd0, dest_pool[4], mask_pool[1], 32'd0,
			1'b0);
		send(dvrt_pkg::OP_PERIOD, '1, '1, '1, '1, '1, '1, '1, 1'b1);

		for (int i = 0; i < 200; i++)
			random_item();
		drain();
		for (int i = 0; i < 240; i++)
			random_item();
		drain();

		$display("%0d items, %0d results (%0d advertised routes), %0d table-full drops",
			items_sent, sb.results_seen, sb.adv_seen, sb.full_seen);
		if (sb.errors == 0)
			$display("** distance_vector_route_table: PASSED **");
		else
			$display("** distance_vector_route_table: FAILED **");
		$finish;
	end

endmodule
